/* rtl/bba_pkg.sv */
// shared types, constants and bit helpers for the bitmap block allocator
// used by every module of the block but bba_ram; depends on nothing

package bba_pkg;

   // map geometry
   localparam int MAP_ROWS  = 64;
   localparam int ROW_BITS  = 64;
   localparam int ROW_IDX_W = $clog2(MAP_ROWS);
   localparam int BIT_IDX_W = $clog2(ROW_BITS);
   localparam int BLOCK_W   = 13;
   localparam int ROWS_W    = 7;
   localparam int STATUS_W  = 2;

   localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(MAP_ROWS);
   localparam logic [ROWS_W-1:0] ROWS_MAX   = ROWS_W'(MAP_ROWS);

   // request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic               op;
      logic [BLOCK_W-1:0] block_number;
   } req_type;

   typedef struct packed {
      logic [BLOCK_W-1:0]  allocated_block;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic find;
      logic update;
      logic publish;
   } bba_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } bba_status_type;

   // mirror a row so the msb lands on bit zero
   function automatic logic [ROW_BITS-1:0] bit_reverse(input logic [ROW_BITS-1:0] v);
      logic [ROW_BITS-1:0] r;
      for (int i = 0; i < ROW_BITS; i++) begin
         r[i] = v[ROW_BITS-1-i];
      end
      return r;
   endfunction

   // keep only the lowest set bit
   function automatic logic [ROW_BITS-1:0] lowest_onehot(input logic [ROW_BITS-1:0] v);
      return v & (~v + ROW_BITS'(1));
   endfunction

   // index of the single set bit of a one-hot word
   function automatic logic [BIT_IDX_W-1:0] onehot_index(input logic [ROW_BITS-1:0] oh);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < ROW_BITS; i++) begin
         if (oh[i]) begin
            idx = idx | BIT_IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

/* rtl/bba_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module bba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* rtl/bba_ctrl.sv */
// sequencing state machine of the bitmap block allocator
// depends on bba_pkg for the command and status structs

module bba_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bba_pkg::bba_status_type dp_status,
   output bba_pkg::bba_cmd_type    dp_cmd
);

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_FIND    = 4'b0010,
      S_UPDATE  = 4'b0100,
      S_PUBLISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_FIND;
         end
         S_FIND:    state_in = S_UPDATE;
         S_UPDATE:  state_in = S_PUBLISH;
         S_PUBLISH: begin
            if (dp_status.out_free) state_in = S_IDLE;
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands to the datapath
   assign req_stall      = (state_ff != S_IDLE);
   assign dp_cmd.capture = (state_ff == S_IDLE) && req_valid;
   assign dp_cmd.find    = (state_ff == S_FIND);
   assign dp_cmd.update  = (state_ff == S_UPDATE);
   assign dp_cmd.publish = (state_ff == S_PUBLISH) && dp_status.out_free;

   // an accepted transaction walks through find and update in order
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> dp_cmd.find ##1 dp_cmd.update)
      else $error("accepted transaction did not reach find and update");

   // at most one command per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(dp_cmd))
      else $error("more than one datapath command at once");

   // no new transaction while one is in flight
   assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.find || dp_cmd.update) |-> req_stall)
      else $error("request channel open during processing");

endmodule

/* rtl/bba_datapath.sv */
// bitmap storage, row full flags, search and update logic of the allocator
// depends on bba_pkg and bba_ram

module bba_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  bba_pkg::bba_cmd_type            dp_cmd,
   output bba_pkg::bba_status_type         dp_status,
   input  bba_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bba_pkg::rsp_type                rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [bba_pkg::ROWS_W-1:0]      csr_wr_data
);

   localparam int RW = bba_pkg::ROW_IDX_W;
   localparam int BW = bba_pkg::BIT_IDX_W;
   localparam int NB = bba_pkg::BLOCK_W;

   // configuration and per-row flags
   logic [bba_pkg::ROWS_W-1:0]   active_rows_ff;
   logic [bba_pkg::MAP_ROWS-1:0] full_ff, full_in;
   logic [bba_pkg::MAP_ROWS-1:0] valid_ff, valid_in;

   // captured transaction and intermediate results
   logic                          op_ff;
   logic [NB-1:0]                 blk_ff;
   logic [RW-1:0]                 row_ff, row_in;
   logic [bba_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [NB-1:0]                 res_block_ff, res_block_in;
   logic                          rsp_valid_ff;
   bba_pkg::rsp_type              rsp_ff;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_rows_ff <= bba_pkg::ROWS_RESET;
      end else if (csr_wr_en) begin
         active_rows_ff <= csr_wr_data;
      end
   end

   // capture the request
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         op_ff  <= req_payload.op;
         blk_ff <= req_payload.block_number;
      end
   end

   // rows in use, clamped to the map size
   logic [bba_pkg::ROWS_W-1:0]   rows_used;
   logic [bba_pkg::MAP_ROWS-1:0] row_mask;
   logic [NB-1:0]                block_limit;
   logic [NB-1:0]                blk_idx;
   logic                         out_of_range;

   always_comb begin
      rows_used = (active_rows_ff > bba_pkg::ROWS_MAX) ? bba_pkg::ROWS_MAX : active_rows_ff;
      for (int i = 0; i < bba_pkg::MAP_ROWS; i++) begin
         row_mask[i] = (bba_pkg::ROWS_W'(i) < rows_used);
      end
      block_limit  = NB'({rows_used, {BW{1'b0}}});
      blk_idx      = blk_ff - NB'(1);
      out_of_range = (blk_ff == '0) || (blk_ff > block_limit);
   end

   // find stage: pick the first row with room, or the row of the freed block
   logic [bba_pkg::MAP_ROWS-1:0] avail_rows;
   logic [bba_pkg::MAP_ROWS-1:0] first_row_oh;

   always_comb begin
      avail_rows   = ~full_ff & row_mask;
      first_row_oh = bba_pkg::lowest_onehot(avail_rows);
      if (op_ff == bba_pkg::OP_ALLOC) begin
         row_in    = bba_pkg::onehot_index(first_row_oh);
         status_in = (avail_rows != '0) ? bba_pkg::ST_OK : bba_pkg::ST_FULL;
      end else begin
         row_in    = blk_idx[RW+BW-1:BW];
         status_in = out_of_range ? bba_pkg::ST_RANGE : bba_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.find) begin
         row_ff    <= row_in;
         status_ff <= status_in;
      end
   end

   // bitmap storage
   logic [bba_pkg::ROW_BITS-1:0] ram_rd_data;
   logic [bba_pkg::ROW_BITS-1:0] new_row;
   logic                         ram_wr_en;

   bba_ram #(
      .WIDTH (bba_pkg::ROW_BITS),
      .DEPTH (bba_pkg::MAP_ROWS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (row_ff),
      .wr_data (new_row),
      .rd_en   (dp_cmd.find),
      .rd_addr (row_in),
      .rd_data (ram_rd_data)
   );

   // update stage: set the first clear bit or clear the freed bit
   logic [bba_pkg::ROW_BITS-1:0] cur_row;
   logic [bba_pkg::ROW_BITS-1:0] grant_oh_rev;
   logic [BW-1:0]                grant_bit;
   logic [BW-1:0]                free_pos;
   logic                         is_alloc;

   always_comb begin
      cur_row      = valid_ff[row_ff] ? ram_rd_data : '0;
      grant_oh_rev = bba_pkg::lowest_onehot(bba_pkg::bit_reverse(~cur_row));
      grant_bit    = bba_pkg::onehot_index(grant_oh_rev);
      free_pos     = blk_idx[BW-1:0];
      is_alloc     = (op_ff == bba_pkg::OP_ALLOC);
      if (is_alloc) begin
         new_row = cur_row | bba_pkg::bit_reverse(grant_oh_rev);
      end else begin
         new_row = cur_row & ~(bba_pkg::ROW_BITS'(1) << (BW'(bba_pkg::ROW_BITS - 1) - free_pos));
      end
      ram_wr_en = dp_cmd.update && (status_ff == bba_pkg::ST_OK);
      res_block_in = (is_alloc && status_ff == bba_pkg::ST_OK) ?
                     NB'({row_ff, grant_bit}) + NB'(1) : '0;
      full_in  = full_ff;
      valid_in = valid_ff;
      if (ram_wr_en) begin
         full_in[row_ff]  = &new_row;
         valid_in[row_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff  <= '0;
         valid_ff <= '0;
      end else begin
         full_ff  <= full_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.update) begin
         res_block_ff <= res_block_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.publish) begin
         rsp_ff.allocated_block <= res_block_ff;
         rsp_ff.status          <= status_ff;
      end
   end

   assign dp_status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload        = rsp_ff;

   // a successful allocate always grants a nonzero block
   assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.publish && op_ff == bba_pkg::OP_ALLOC && status_ff == bba_pkg::ST_OK)
      |-> (res_block_ff != '0))
      else $error("successful allocate granted block zero");

   // frees and failed requests report block zero
   assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.publish && (op_ff == bba_pkg::OP_FREE || status_ff != bba_pkg::ST_OK))
      |-> (res_block_ff == '0))
      else $error("nonzero block on free or failed request");

   // full flag tracks the row just written
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> (full_ff[$past(row_ff)] == (&$past(new_row))))
      else $error("row full flag out of step with written row");

   // a successful free leaves its row with room
   assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && op_ff == bba_pkg::OP_FREE) |=> !full_ff[$past(row_ff)])
      else $error("row still full after a free");

endmodule

/* rtl/bitmap_block_allocator.sv */
// Bitmap block allocator, first fit over a used-block map of 64-bit rows.
//
// Request channel (req_valid, req_stall, req_payload): op selects allocate
// or free; block_number is the 1-based block to free. Block n lives in row
// (n-1)/64 at bit 63-((n-1)%64). Response channel (rsp_valid, rsp_stall,
// rsp_payload) returns one transaction per request: the granted block (0
// for a free or when the map is full) and a status of ok, full or out of
// range. csr_wr_en/csr_wr_data write the number of active rows; write it
// only while no request is in flight.
// After acceptance a request is processed in order: find the first row
// with space from the per-row full flags (or the row of the block to free),
// read-modify-write of that row in the map memory, then load the output
// register. One request is handled at a time: req_stall holds off the next
// request until the current one has loaded the output register.
// Reset clears all row valid and full flags, so the whole map reads as free
// at once, and sets active rows to 64. While rsp_stall holds the output
// register, the next request is still accepted and processed; it waits in
// the publish step until the output register frees up.
// Depends on bba_pkg, bba_ctrl, bba_datapath and bba_ram.

module bitmap_block_allocator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  bba_pkg::req_type           req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output bba_pkg::rsp_type           rsp_payload,
   input  logic                       csr_wr_en,
   input  logic [bba_pkg::ROWS_W-1:0] csr_wr_data
);

   bba_pkg::bba_cmd_type    dp_cmd;
   bba_pkg::bba_status_type dp_status;

   // sequencer
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // map, flags and output register
   bba_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

/* dv/bba_monitor.sv */
// watches both channels and the row-count port of the bitmap block allocator,
// predicts every response from its own copy of the used-block map, and counts mismatches
// depends on bba_pkg

module bba_monitor
   import bba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_type           req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_type           rsp_payload,
   input  logic              csr_wr_en,
   input  logic [ROWS_W-1:0] csr_wr_data,
   output int                mismatches,
   output int                owed
);

   // shadow copy of the map and of the row count
   logic [ROW_BITS-1:0] used_rows [MAP_ROWS];
   logic [ROWS_W-1:0]   rows_cfg;
   rsp_type             owed_rsp [$];
   int                  fails;

   // first fit over the active rows, msb of a row is the lowest block
   function automatic rsp_type allocate_or_free(input req_type r);
      rsp_type     res;
      int unsigned rows;
      int unsigned idx;
      bit          found;
      rows = (rows_cfg > MAP_ROWS) ? MAP_ROWS : rows_cfg;
      res.allocated_block = '0;
      res.status = ST_OK;
      found = 1'b0;
      if (r.op == OP_ALLOC) begin
         res.status = ST_FULL;
         for (int row = 0; row < rows && !found; row++) begin
            for (int b = 0; b < ROW_BITS && !found; b++) begin
               if (!used_rows[row][ROW_BITS-1-b]) begin
                  used_rows[row][ROW_BITS-1-b] = 1'b1;
                  res.allocated_block = BLOCK_W'(row * ROW_BITS + b + 1);
                  res.status = ST_OK;
                  found = 1'b1;
               end
            end
         end
      end else if (r.block_number == 0 || r.block_number > rows * ROW_BITS) begin
         res.status = ST_RANGE;
      end else begin
         // freeing an already free block leaves the bit clear
         idx = r.block_number - 1;
         used_rows[idx / ROW_BITS][ROW_BITS-1-(idx % ROW_BITS)] = 1'b0;
      end
      return res;
   endfunction

   // compare responses first: a request accepted this edge cannot answer yet
   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         foreach (used_rows[i]) used_rows[i] = '0;
         rows_cfg = ROWS_RESET;
         owed_rsp.delete();
         fails = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = rsp_payload;
            if (owed_rsp.size() == 0) begin
               $display("%0t: unexpected transaction, got block %0d status %0d",
                        $time, seen.allocated_block, seen.status);
               fails++;
            end else begin
               want = owed_rsp.pop_front();
               if (seen.allocated_block !== want.allocated_block) begin
                  $display("%0t: allocated_block expected %0d, got %0d",
                           $time, want.allocated_block, seen.allocated_block);
                  fails++;
               end
               if (seen.status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, seen.status);
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            owed_rsp.push_back(allocate_or_free(req_payload));
         end
         if (csr_wr_en) begin
            rows_cfg = csr_wr_data;
         end
      end
      mismatches <= fails;
      owed <= owed_rsp.size();
   end

endmodule

/* dv/testbench.sv */
// top of the allocator testbench: clock, reset, request stimulus, row-count writes
// and response stalls; depends on bba_pkg, bba_monitor and bitmap_block_allocator

module testbench;
   import bba_pkg::*;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   rsp_type           rsp_payload;
   logic              csr_wr_en   = 1'b0;
   logic [ROWS_W-1:0] csr_wr_data = '0;
   logic              hold_req    = 1'b0;
   int                mismatches;
   int                owed;
   int                burst_left  = 0;

   // receiver state
   int hold_count = 0;
   int stall_mode = 0;
   int rx_cycle   = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   bitmap_block_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bba_monitor monitor (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .owed        (owed)
   );

   // response stalls: a long hold on request, otherwise a randomly picked stall mode
   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) begin
         stall_mode = $urandom_range(0, 3);
      end
      if (hold_count != 0) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count - 1;
      end else if (hold_req) begin
         rsp_stall <= 1'b1;
         hold_count <= 80;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(99) < 30);
            2: rsp_stall <= ($urandom_range(99) < 70);
            default: rsp_stall <= (rx_cycle % 7 < 3);
         endcase
      end
   end

   // present one transaction and wait until it is taken
   task automatic offer(input logic op, input logic [BLOCK_W-1:0] blk);
      req_valid <= 1'b1;
      req_payload <= '{op: op, block_number: blk};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // stop sending and wait for every owed response, then let the pipeline drain
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_rows(input logic [ROWS_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // one random transaction; frees lean toward low blocks, where first fit allocates
   task automatic random_item(input int unsigned alloc_pct, input int unsigned span);
      logic               op;
      logic [BLOCK_W-1:0] blk;
      int unsigned        pick;
      op = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE;
      pick = $urandom_range(99);
      if (op == OP_ALLOC) begin
         blk = BLOCK_W'($urandom);
      end else if (pick < 60 && span != 0) begin
         blk = BLOCK_W'($urandom_range(1, (span < 96) ? span : 96));
      end else if (pick < 85 && span != 0) begin
         blk = BLOCK_W'($urandom_range(1, span));
      end else begin
         blk = BLOCK_W'($urandom_range(0, 8191));
      end
      offer(op, blk);
      // bursts of random length, sometimes without a gap after them
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(3) != 0) pause($urandom_range(1, 9));
      end
   endtask

   task automatic run_phase(input logic [ROWS_W-1:0] rows, input int items,
                            input int unsigned alloc_pct);
      int unsigned span;
      settle();
      write_rows(rows);
      span = ((rows > MAP_ROWS) ? MAP_ROWS : rows) * ROW_BITS;
      repeat (items) random_item(alloc_pct, span);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset row count, ignored block field, double free, range edges
      offer(OP_ALLOC, '0);
      offer(OP_ALLOC, '1);
      offer(OP_FREE, 13'd1);
      offer(OP_FREE, 13'd1);
      offer(OP_ALLOC, 13'd4096);
      offer(OP_FREE, 13'd0);
      offer(OP_FREE, 13'd4096);
      offer(OP_FREE, 13'd4097);
      offer(OP_FREE, '1);
      // no rows managed
      settle();
      write_rows(7'd0);
      offer(OP_ALLOC, '0);
      offer(OP_FREE, 13'd1);
      // row count above the map size
      settle();
      write_rows(7'd127);
      offer(OP_FREE, 13'd4096);
      offer(OP_FREE, 13'd4097);
      offer(OP_ALLOC, '0);
      // single row, last block and first block past it
      settle();
      write_rows(7'd1);
      offer(OP_FREE, 13'd64);
      offer(OP_FREE, 13'd65);
      offer(OP_ALLOC, '0);

      // random: small maps fill up, shrink and grow again
      run_phase(7'd1, 100, 75);
      run_phase(7'd2, 80, 70);
      run_phase(7'd1, 40, 50);
      run_phase(7'd3, 60, 60);
      run_phase(7'd64, 60, 60);

      // long response hold while requests keep coming, so the input backs up
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      repeat (12) offer(OP_ALLOC, BLOCK_W'($urandom));

      run_phase(7'd0, 25, 50);
      run_phase(7'd127, 50, 60);
      run_phase(7'd65, 40, 60);
      run_phase(7'd1, 80, 85);
      run_phase(ROWS_W'($urandom_range(0, 127)), 90, 60);

      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_ctrl.sv
rtl/bba_datapath.sv
rtl/bitmap_block_allocator.sv
dv/bba_monitor.sv
dv/testbench.sv
